>>> rtl/core/bba_pkg.sv
// Shared constants, codes and types for the bitmap block allocator.
// Used by every module of the allocator core except bba_ram, and by its checker.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int NUM_BLOCKS = 4096;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = NUM_BLOCKS / WORD_BITS;
  localparam int ADDR_W     = $clog2(MAP_WORDS);
  localparam int POS_W      = $clog2(WORD_BITS);
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = 13;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 3;

  localparam logic [CNT_W-1:0]   LIMIT_MAX = CNT_W'(NUM_BLOCKS);
  localparam logic [PADDR_W-3:0] REG_TOTAL = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_TEST,
    CMD_RSVD
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_FULL,
    ST_RANGE,
    ST_FREE
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RMW,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    status_e          status;
    logic             bitv;
    logic [CNT_W-1:0] free;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/bba_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output      logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bba_cfg.sv
// APB register bank holding total_blocks and giving the saturated allocation limit.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bba_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bba_pkg::DATA_W-1:0]   pwdata,
  output      logic [bba_pkg::DATA_W-1:0]   prdata,
  output      logic                         pready,
  output      logic [bba_pkg::CNT_W-1:0]    limit_o
);
  import bba_pkg::*;

  logic [CNT_W-1:0] total_q, total_d;
  logic             hit;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1:2] == REG_TOTAL);

  always_comb begin
    total_d = total_q;
    if (psel && penable && pwrite && pready && hit) begin
      total_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= LIMIT_MAX;
    end else begin
      total_q <= total_d;
    end
  end

  assign prdata  = hit ? DATA_W'(total_q) : '0;
  assign limit_o = (total_q > LIMIT_MAX) ? LIMIT_MAX : total_q;

endmodule

`default_nettype wire

>>> rtl/core/bba_engine.sv
// Command sequencer: word scan for allocate, read-modify-write for free, read for test.
// Depends on bba_pkg; drives the bitmap RAM ports and the result register.
`timescale 1ns / 1ps
`default_nettype none

module bba_engine (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [bba_pkg::CNT_W-1:0]   limit_i,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [bba_pkg::CMD_W-1:0]   command_i,
  input  wire logic [bba_pkg::BLK_W-1:0]   block_number_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      bba_pkg::res_t               res_o,
  output      logic                        rd_en_o,
  output      logic [bba_pkg::ADDR_W-1:0]  rd_addr_o,
  input  wire logic [bba_pkg::WORD_BITS-1:0] rd_data_i,
  output      logic                        wr_en_o,
  output      logic [bba_pkg::ADDR_W-1:0]  wr_addr_o,
  output      logic [bba_pkg::WORD_BITS-1:0] wr_data_o
);
  import bba_pkg::*;

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [BLK_W-1:0]     blk_q, blk_d;
  logic [CNT_W-1:0]     lim_q, lim_d;
  logic [ADDR_W-1:0]    chk_q, chk_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic [BLK_W-1:0]     res_blk_q, res_blk_d;
  status_e              status_q, status_d;
  logic                 bitv_q, bitv_d;
  logic [MAP_WORDS-1:0] valid_q;
  logic                 rd_vld_q;
  logic                 out_valid_q;
  res_t                 res_q;
  logic                 out_load;

  logic [WORD_BITS-1:0] word;
  logic [CNT_W-1:0]     rem;
  logic [WORD_BITS-1:0] cand;
  logic                 found;
  logic [POS_W-1:0]     pos;
  logic [ADDR_W:0]      chk_nx;
  logic                 last;
  logic [POS_W-1:0]     bit_idx;
  logic                 bit_rd;
  logic                 in_alloc;
  logic                 in_range;
  logic                 lim_zero;

  // Words never written read as all free.
  assign word = rd_vld_q ? rd_data_i : '0;

  always_comb begin
    rem = lim_q - CNT_W'({chk_q, {POS_W{1'b0}}});
    for (int o = 0; o < WORD_BITS; o++) begin
      cand[o] = !word[WORD_BITS-1-o] && (rem > CNT_W'(o));
    end
    found = |cand;
    pos   = '0;
    for (int o = WORD_BITS-1; o >= 0; o--) begin
      if (cand[o]) begin
        pos = POS_W'(o);
      end
    end
  end

  assign chk_nx   = {1'b0, chk_q} + 1'b1;
  assign last     = (CNT_W'({chk_nx, {POS_W{1'b0}}}) >= lim_q);
  assign bit_idx  = POS_W'(WORD_BITS-1) - blk_q[POS_W-1:0];
  assign bit_rd   = word[bit_idx];
  assign in_alloc = (cmd_e'(command_i) == CMD_ALLOC);
  assign in_range = ({1'b0, block_number_i} >= limit_i);
  assign lim_zero = (limit_i == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_alloc) begin
            state_d = lim_zero ? S_DONE : S_SCAN;
          end else begin
            state_d = in_range ? S_DONE : S_RMW;
          end
        end
      end
      S_SCAN: begin
        if (found || last) begin
          state_d = S_DONE;
        end
      end
      S_RMW: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    wr_en_o   = 1'b0;
    wr_addr_o = chk_q;
    wr_data_o = word;
    cmd_d     = cmd_q;
    blk_d     = blk_q;
    lim_d     = lim_q;
    chk_d     = chk_q;
    used_d    = used_q;
    res_blk_d = res_blk_q;
    status_d  = status_q;
    bitv_d    = bitv_q;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = cmd_e'(command_i);
          blk_d    = block_number_i;
          lim_d    = limit_i;
          chk_d    = '0;
          bitv_d   = 1'b0;
          status_d = ST_OK;
          rd_en_o  = 1'b1;
          if (in_alloc) begin
            rd_addr_o = '0;
            res_blk_d = '0;
            if (lim_zero) begin
              status_d = ST_FULL;
            end
          end else begin
            rd_addr_o = block_number_i[BLK_W-1:POS_W];
            res_blk_d = block_number_i;
            if (in_range) begin
              status_d = ST_RANGE;
            end
          end
        end
      end
      S_SCAN: begin
        rd_en_o   = 1'b1;
        rd_addr_o = chk_nx[ADDR_W-1:0];
        if (found) begin
          wr_en_o   = 1'b1;
          wr_addr_o = chk_q;
          wr_data_o = word | (WORD_BITS'(1) << (POS_W'(WORD_BITS-1) - pos));
          used_d    = used_q + 1'b1;
          res_blk_d = {chk_q, pos};
        end else if (last) begin
          status_d = ST_FULL;
        end else begin
          chk_d = chk_nx[ADDR_W-1:0];
        end
      end
      S_RMW: begin
        bitv_d = bit_rd;
        if (cmd_q == CMD_FREE) begin
          if (bit_rd) begin
            wr_en_o   = 1'b1;
            wr_addr_o = blk_q[BLK_W-1:POS_W];
            wr_data_o = word & ~(WORD_BITS'(1) << bit_idx);
            used_d    = used_q - 1'b1;
          end else begin
            status_d = ST_FREE;
          end
        end
      end
      S_DONE: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (wr_en_o) begin
        valid_q[wr_addr_o] <= 1'b1;
      end
      if (rd_en_o) begin
        rd_vld_q <= valid_q[rd_addr_o];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    blk_q     <= blk_d;
    lim_q     <= lim_d;
    chk_q     <= chk_d;
    res_blk_q <= res_blk_d;
    status_q  <= status_d;
    bitv_q    <= bitv_d;
    if (out_load) begin
      res_q.blk    <= res_blk_q;
      res_q.status <= status_q;
      res_q.bitv   <= bitv_q;
      res_q.free   <= (lim_q > used_q) ? (lim_q - used_q) : '0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> rtl/core/bitmap_block_allocator_core.sv
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg, bba_cfg, bba_engine and bba_ram.
//
// Usage:
//   Input beats carry command_i (allocate, free, test) and block_number_i and
//   are taken when in_valid_i is high and in_stall_o is low. Each beat gives
//   one output beat with result_block_o, status_o, bit_value_o, free_count_o,
//   taken when out_valid_o is high and out_stall_i is low.
//   The bitmap lives in a 128 x 32 RAM with a registered read port.
//   Allocate streams one bitmap word per cycle through a first-free search,
//   sets the first free bit it finds below the limit and then loads the
//   result. Free reads, modifies and writes one word; test only reads one.
//   An out-of-range block or a zero limit goes straight to the result with
//   no scan or write. One command is in work at a time; the next beat is
//   taken in the cycle after the result is loaded.
//   The result register holds while out_stall_i is high, and a new beat may
//   be taken and worked on meanwhile up to its result.
//   Reset marks every bitmap word as never written (all free) at once, with
//   no clearing pass, zeroes the used count and sets total_blocks to 4096.
//   total_blocks sits at APB byte address 0; write it only while idle.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [bba_pkg::CMD_W-1:0]   command_i,
  input  wire logic [bba_pkg::BLK_W-1:0]   block_number_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [bba_pkg::BLK_W-1:0]   result_block_o,
  output      logic [bba_pkg::STAT_W-1:0]  status_o,
  output      logic                        bit_value_o,
  output      logic [bba_pkg::CNT_W-1:0]   free_count_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bba_pkg::PADDR_W-1:0] paddr,
  input  wire logic [bba_pkg::DATA_W-1:0]  pwdata,
  output      logic [bba_pkg::DATA_W-1:0]  prdata,
  output      logic                        pready
);
  import bba_pkg::*;

  logic [CNT_W-1:0]     limit;
  res_t                 res;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  bba_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  bba_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .limit_i        (limit),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .block_number_i (block_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .res_o          (res),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data)
  );

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign result_block_o = res.blk;
  assign status_o       = res.status;
  assign bit_value_o    = res.bitv;
  assign free_count_o   = res.free;

endmodule

`default_nettype wire

>>> rtl/core/bba_chk.sv
// Port-level checker for the allocator core, bound to the top level.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bba_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [bba_pkg::BLK_W-1:0]   result_block_o,
  input wire logic [bba_pkg::STAT_W-1:0]  status_o,
  input wire logic                        bit_value_o,
  input wire logic [bba_pkg::CNT_W-1:0]   free_count_o
);
  import bba_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_block_o)
      && $stable(status_o) && $stable(bit_value_o) && $stable(free_count_o))
    else $error("stalled output beat changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second beat taken while a command is in work");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |->
      (result_block_o == '0) && !bit_value_o && (free_count_o == '0))
    else $error("full report with nonzero block, bit or free count");

  a_no_bit_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_RANGE) || (status_o == ST_FREE)) |-> !bit_value_o)
    else $error("error report with used bit set");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (free_count_o <= LIMIT_MAX))
    else $error("free count above block total");

endmodule

bind bitmap_block_allocator_core bba_chk u_bba_chk (.*);

`default_nettype wire
